// File: src/cuckoo_hash_map_core_assert.svh
// ----------------------------------------------------------------------------
// cuckoo hash map assertion macros
// concurrent assertion wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef CUCKOO_HASH_MAP_CORE_ASSERT_SVH
`define CUCKOO_HASH_MAP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CHM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chm assertion failed");
// next-cycle implication
`define CHM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chm assertion failed");
`else
`define CHM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CHM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: src/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// shared codes, widths and control structs of the cuckoo hash map
// ----------------------------------------------------------------------------
package chm_pkg;

    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int TS_W       = 11;
    localparam int LIM_W      = 12;
    localparam int KICK_W     = 8;
    localparam int CNT_OUT_W  = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int HASH_MUL   = 13;

    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEL    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] ST_KICK = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KICKS   = 2'd2;

    localparam logic [TS_W-1:0]   RST_TABLE_SIZE  = 11'd1024;
    localparam logic [LIM_W-1:0]  RST_ENTRY_LIMIT = 12'd1024;
    localparam logic [KICK_W-1:0] RST_MAX_KICKS   = 8'd16;

    typedef struct packed {
        logic                clr_we;
        logic                load;
        logic                mod_key;
        logic                mod_ck;
        logic                mod_13;
        logic                set_s1;
        logic                set_s2;
        logic                look;
        logic                upd1;
        logic                upd2;
        logic                del1;
        logic                del2;
        logic                put1;
        logic                put2;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                round_clr;
        logic                round_inc;
        logic                finish;
        logic [STATUS_W-1:0] status;
    } chm_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic mod_done;
        logic is_add;
        logic is_del;
        logic in1;
        logic in2;
        logic rd1_valid;
        logic rd2_valid;
        logic at_limit;
        logic kicks_zero;
        logic round_last;
    } chm_stat_t;

endpackage

// File: src/cuckoo_hash_map_core.sv
// ----------------------------------------------------------------------------
// cuckoo_hash_map_core
// two-table cuckoo hash map with search, add/update and remove requests
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low; its single result
// is marked by done, which is high for exactly one cycle, and it cannot be
// held off by the receiver, so capture it when done is high. each request
// runs one at a time. the slot hashes come from a shared bit-serial remainder
// unit, whose dividend width DW is the larger of KEY_BITS and
// log2(TABLE_DEPTH)+4. a search, a remove, an update or an add that lands in
// its first-table slot finishes straight after its lookup; busy is already
// low in the done cycle, so the next request can be taken at the edge that
// ends the done cycle. each move of the carried entry into the second table
// runs the hash unit twice and each move back into the first table runs it
// once; an insertion that runs out of rounds reports the homeless entry from
// a state of its own. after reset the block sweeps every slot of both tables
// to clear their valid flags and holds busy high meanwhile.
// configuration writes are always ready and should be issued while idle.
// ----------------------------------------------------------------------------
`include "cuckoo_hash_map_core_assert.svh"

module cuckoo_hash_map_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request transaction
    input  logic                                start,
    output logic                                busy,
    input  logic [chm_pkg::MODE_W-1:0]          mode,
    input  logic signed [KEY_BITS-1:0]          key,
    input  logic signed [VALUE_BITS-1:0]        value,
    // result transaction
    output logic                                done,
    output logic                                hit,
    output logic signed [VALUE_BITS-1:0]        old_value,
    output logic [chm_pkg::STATUS_W-1:0]        status,
    output logic [chm_pkg::CNT_OUT_W-1:0]       entry_count,
    output logic signed [KEY_BITS-1:0]          homeless_key,
    output logic signed [VALUE_BITS-1:0]        homeless_value,
    // configuration write transaction
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [chm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [chm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    chm_pkg::chm_cmd_t  cmd;
    chm_pkg::chm_stat_t stat;

    logic [chm_pkg::TS_W-1:0]   table_size_reg;
    logic [chm_pkg::LIM_W-1:0]  entry_limit_reg;
    logic [chm_pkg::KICK_W-1:0] max_kicks_reg;

    // config registers; writes to unused indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg  <= chm_pkg::RST_TABLE_SIZE;
            entry_limit_reg <= chm_pkg::RST_ENTRY_LIMIT;
            max_kicks_reg   <= chm_pkg::RST_MAX_KICKS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                chm_pkg::CFG_TABLE_SIZE:
                begin
                    table_size_reg <= cfg_data[chm_pkg::TS_W-1:0];
                end
                chm_pkg::CFG_ENTRY_LIMIT:
                begin
                    entry_limit_reg <= cfg_data[chm_pkg::LIM_W-1:0];
                end
                chm_pkg::CFG_MAX_KICKS:
                begin
                    max_kicks_reg <= cfg_data[chm_pkg::KICK_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // sequencer: owns request flow and the eviction loop
    chm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // tables, hash unit and result registers
    chm_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_mode       (mode),
        .req_key        (key),
        .req_value      (value),
        .table_size     (table_size_reg),
        .entry_limit    (entry_limit_reg),
        .max_kicks      (max_kicks_reg),
        .done           (done),
        .hit            (hit),
        .old_value      (old_value),
        .status         (status),
        .entry_count    (entry_count),
        .homeless_key   (homeless_key),
        .homeless_value (homeless_value)
    );

    // a freshly taken request never completes in the following cycle
    `CHM_ASSERT_NEXT(a_no_instant_done, clk, rst_n, start && !busy, !done)
    // the result strobe always lands with the sequencer back at idle
    `CHM_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    // a failed eviction only follows a key that was absent
    `CHM_ASSERT_IMP(a_kick_no_hit, clk, rst_n, done && (status == chm_pkg::ST_KICK), !hit)
    // a present key never reports a refusal at the entry limit
    `CHM_ASSERT_IMP(a_full_no_hit, clk, rst_n, done && (status == chm_pkg::ST_FULL), !hit)

endmodule

// File: src/chm_mod_unit.sv
// ----------------------------------------------------------------------------
// chm_mod_unit
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module chm_mod_unit #(
    parameter int DW = 32,
    parameter int NW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [NW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] rem
);

    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   quo_reg;
    logic [NW-1:0]   rem_reg;
    logic [NW-1:0]   div_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            run_reg;
    logic            done_reg;
    logic [NW:0]     shifted;
    logic [NW:0]     rem_next;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[DW-1]};
        if (shifted >= {1'b0, div_reg})
        begin
            rem_next = shifted - {1'b0, div_reg};
        end
        else
        begin
            rem_next = shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNTW'(DW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], 1'b0};
            rem_reg <= rem_next[NW-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: src/chm_datapath.sv
// ----------------------------------------------------------------------------
// chm_datapath
// both hash tables, the hash unit, carried entry and result registers
// ----------------------------------------------------------------------------
module chm_datapath #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  chm_pkg::chm_cmd_t                   cmd,
    output chm_pkg::chm_stat_t                  stat,
    input  logic [chm_pkg::MODE_W-1:0]          req_mode,
    input  logic signed [KEY_BITS-1:0]          req_key,
    input  logic signed [VALUE_BITS-1:0]        req_value,
    input  logic [chm_pkg::TS_W-1:0]            table_size,
    input  logic [chm_pkg::LIM_W-1:0]           entry_limit,
    input  logic [chm_pkg::KICK_W-1:0]          max_kicks,
    output logic                                done,
    output logic                                hit,
    output logic signed [VALUE_BITS-1:0]        old_value,
    output logic [chm_pkg::STATUS_W-1:0]        status,
    output logic [chm_pkg::CNT_OUT_W-1:0]       entry_count,
    output logic signed [KEY_BITS-1:0]          homeless_key,
    output logic signed [VALUE_BITS-1:0]        homeless_value
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = $clog2(2 * TABLE_DEPTH + 1);
    localparam int DW = (KEY_BITS > AW + 4) ? KEY_BITS : AW + 4;
    localparam int RW = 1 + KEY_BITS + VALUE_BITS;

    logic [RW-1:0] mem1 [TABLE_DEPTH];
    logic [RW-1:0] mem2 [TABLE_DEPTH];
    logic [RW-1:0] rd1_reg;
    logic [RW-1:0] rd2_reg;

    logic [AW-1:0] s1_reg;
    logic [AW-1:0] s2_reg;
    logic [AW-1:0] clr_reg;

    logic [chm_pkg::MODE_W-1:0] mode_reg;
    logic [KEY_BITS-1:0]        key_reg;
    logic [VALUE_BITS-1:0]      val_reg;
    logic [KEY_BITS-1:0]        ck_reg;
    logic [VALUE_BITS-1:0]      cv_reg;
    logic [CW-1:0]              cnt_reg;
    logic [chm_pkg::KICK_W-1:0] round_reg;

    logic                         done_reg;
    logic                         hit_reg;
    logic [VALUE_BITS-1:0]        old_reg;
    logic [chm_pkg::STATUS_W-1:0] status_reg;
    logic [KEY_BITS-1:0]          hk_reg;
    logic [VALUE_BITS-1:0]        hv_reg;

    logic                  rd1_valid;
    logic                  rd2_valid;
    logic [KEY_BITS-1:0]   rd1_key;
    logic [KEY_BITS-1:0]   rd2_key;
    logic [VALUE_BITS-1:0] rd1_val;
    logic [VALUE_BITS-1:0] rd2_val;
    logic                  in1;
    logic                  in2;

    logic          mod_start;
    logic [DW-1:0] mod_dvd;
    logic [NW-1:0] eff_size;
    logic          mod_done;
    logic [NW-1:0] mod_rem;
    logic [31:0]   ts_ext;

    logic          we1;
    logic          we2;
    logic [AW-1:0] wa1;
    logic [AW-1:0] wa2;
    logic [RW-1:0] wd1;
    logic [RW-1:0] wd2;

    function automatic logic [KEY_BITS-1:0] magnitude(input logic [KEY_BITS-1:0] k);
        logic [KEY_BITS-1:0] m;
        m = k[KEY_BITS-1] ? (~k + 1'b1) : k;
        return m;
    endfunction

    // clamp the configured size into 1 .. TABLE_DEPTH
    always_comb
    begin
        ts_ext = 32'(table_size);
        if (ts_ext == 32'd0)
        begin
            ts_ext = 32'd1;
        end
        else if (ts_ext > 32'(TABLE_DEPTH))
        begin
            ts_ext = 32'(TABLE_DEPTH);
        end
        eff_size = NW'(ts_ext);
    end

    assign mod_start = cmd.mod_key | cmd.mod_ck | cmd.mod_13;

    always_comb
    begin
        if (cmd.mod_key)
        begin
            mod_dvd = DW'(magnitude(req_key));
        end
        else if (cmd.mod_ck)
        begin
            mod_dvd = DW'(magnitude(ck_reg));
        end
        else
        begin
            mod_dvd = DW'(mod_rem) * DW'(chm_pkg::HASH_MUL);
        end
    end

    chm_mod_unit #(
        .DW (DW),
        .NW (NW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_dvd),
        .divisor  (eff_size),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign rd1_valid = rd1_reg[RW-1];
    assign rd2_valid = rd2_reg[RW-1];
    assign rd1_key   = rd1_reg[RW-2 -: KEY_BITS];
    assign rd2_key   = rd2_reg[RW-2 -: KEY_BITS];
    assign rd1_val   = rd1_reg[VALUE_BITS-1:0];
    assign rd2_val   = rd2_reg[VALUE_BITS-1:0];
    assign in1       = rd1_valid && (rd1_key == key_reg);
    assign in2       = !in1 && rd2_valid && (rd2_key == key_reg);

    // write port selection
    always_comb
    begin
        we1 = cmd.clr_we | cmd.upd1 | cmd.del1 | cmd.put1;
        we2 = cmd.clr_we | cmd.upd2 | cmd.del2 | cmd.put2;
        wa1 = cmd.clr_we ? clr_reg : s1_reg;
        wa2 = cmd.clr_we ? clr_reg : s2_reg;
        if (cmd.clr_we)
        begin
            wd1 = '0;
        end
        else if (cmd.upd1)
        begin
            wd1 = {1'b1, rd1_key, val_reg};
        end
        else if (cmd.del1)
        begin
            wd1 = {1'b0, rd1_key, rd1_val};
        end
        else
        begin
            wd1 = {1'b1, ck_reg, cv_reg};
        end
        if (cmd.clr_we)
        begin
            wd2 = '0;
        end
        else if (cmd.upd2)
        begin
            wd2 = {1'b1, rd2_key, val_reg};
        end
        else if (cmd.del2)
        begin
            wd2 = {1'b0, rd2_key, rd2_val};
        end
        else
        begin
            wd2 = {1'b1, ck_reg, cv_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            mem1[wa1] <= wd1;
        end
        rd1_reg <= mem1[s1_reg];
    end

    always_ff @(posedge clk)
    begin
        if (we2)
        begin
            mem2[wa2] <= wd2;
        end
        rd2_reg <= mem2[s2_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_s1)
        begin
            s1_reg <= AW'(mod_rem);
        end
        if (cmd.set_s2)
        begin
            s2_reg <= AW'(mod_rem);
        end
        if (cmd.load)
        begin
            mode_reg <= req_mode;
            key_reg  <= req_key;
            val_reg  <= req_value;
            ck_reg   <= req_key;
            cv_reg   <= req_value;
        end
        else if (cmd.put1)
        begin
            ck_reg <= rd1_key;
            cv_reg <= rd1_val;
        end
        else if (cmd.put2)
        begin
            ck_reg <= rd2_key;
            cv_reg <= rd2_val;
        end
        if (cmd.look)
        begin
            hit_reg <= in1 | in2;
            old_reg <= in1 ? rd1_val : (in2 ? rd2_val : '0);
        end
        if (cmd.finish)
        begin
            status_reg <= cmd.status;
            hk_reg     <= (cmd.status == chm_pkg::ST_KICK) ? ck_reg : '0;
            hv_reg     <= (cmd.status == chm_pkg::ST_KICK) ? cv_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            cnt_reg   <= '0;
            round_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clr_we)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.cnt_dec)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.round_clr)
            begin
                round_reg <= '0;
            end
            else if (cmd.round_inc)
            begin
                round_reg <= round_reg + 1'b1;
            end
            done_reg <= cmd.finish;
        end
    end

    always_comb
    begin
        stat            = '0;
        stat.clr_last   = (clr_reg == AW'(TABLE_DEPTH - 1));
        stat.mod_done   = mod_done;
        stat.is_add     = (mode_reg == chm_pkg::MODE_ADD);
        stat.is_del     = (mode_reg == chm_pkg::MODE_DEL);
        stat.in1        = in1;
        stat.in2        = in2;
        stat.rd1_valid  = rd1_valid;
        stat.rd2_valid  = rd2_valid;
        stat.at_limit   = (32'(cnt_reg) >= 32'(entry_limit));
        stat.kicks_zero = (max_kicks == '0);
        stat.round_last = (({1'b0, round_reg} + 1'b1) == {1'b0, max_kicks});
    end

    assign done           = done_reg;
    assign hit            = hit_reg;
    assign old_value      = old_reg;
    assign status         = status_reg;
    assign entry_count    = chm_pkg::CNT_OUT_W'(32'(cnt_reg));
    assign homeless_key   = hk_reg;
    assign homeless_value = hv_reg;

endmodule

// File: src/chm_ctrl.sv
// ----------------------------------------------------------------------------
// chm_ctrl
// request sequencer: lookup, update, remove and eviction rounds
// ----------------------------------------------------------------------------
module chm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  chm_pkg::chm_stat_t stat,
    output chm_pkg::chm_cmd_t  cmd,
    output logic               busy
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_RQ_H1  = 4'd2;
    localparam logic [3:0] S_RQ_H2  = 4'd3;
    localparam logic [3:0] S_RQ_RD  = 4'd4;
    localparam logic [3:0] S_LOOK   = 4'd5;
    localparam logic [3:0] S_KB_ST  = 4'd6;
    localparam logic [3:0] S_KB_H1  = 4'd7;
    localparam logic [3:0] S_KB_H2  = 4'd8;
    localparam logic [3:0] S_KB_RD  = 4'd9;
    localparam logic [3:0] S_KB_CHK = 4'd10;
    localparam logic [3:0] S_KA_ST  = 4'd11;
    localparam logic [3:0] S_KA_H   = 4'd12;
    localparam logic [3:0] S_KA_RD  = 4'd13;
    localparam logic [3:0] S_KA_CHK = 4'd14;
    localparam logic [3:0] S_KICKED = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load    = 1'b1;
                    cmd.mod_key = 1'b1;
                    state_next  = S_RQ_H1;
                end
            end
            S_RQ_H1:
            begin
                if (stat.mod_done)
                begin
                    cmd.set_s1 = 1'b1;
                    cmd.mod_13 = 1'b1;
                    state_next = S_RQ_H2;
                end
            end
            S_RQ_H2:
            begin
                if (stat.mod_done)
                begin
                    cmd.set_s2 = 1'b1;
                    state_next = S_RQ_RD;
                end
            end
            S_RQ_RD:
            begin
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = S_IDLE;
                if (stat.is_add)
                begin
                    if (stat.in1)
                    begin
                        cmd.upd1   = 1'b1;
                        cmd.finish = 1'b1;
                        cmd.status = chm_pkg::ST_DONE;
                    end
                    else if (stat.in2)
                    begin
                        cmd.upd2   = 1'b1;
                        cmd.finish = 1'b1;
                        cmd.status = chm_pkg::ST_DONE;
                    end
                    else if (stat.at_limit)
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = chm_pkg::ST_FULL;
                    end
                    else if (stat.kicks_zero)
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = chm_pkg::ST_KICK;
                    end
                    else
                    begin
                        cmd.round_clr = 1'b1;
                        cmd.put1      = 1'b1;
                        if (!stat.rd1_valid)
                        begin
                            cmd.cnt_inc = 1'b1;
                            cmd.finish  = 1'b1;
                            cmd.status  = chm_pkg::ST_DONE;
                        end
                        else
                        begin
                            state_next = S_KB_ST;
                        end
                    end
                end
                else if (stat.is_del)
                begin
                    cmd.finish = 1'b1;
                    if (stat.in1)
                    begin
                        cmd.del1    = 1'b1;
                        cmd.cnt_dec = 1'b1;
                        cmd.status  = chm_pkg::ST_DONE;
                    end
                    else if (stat.in2)
                    begin
                        cmd.del2    = 1'b1;
                        cmd.cnt_dec = 1'b1;
                        cmd.status  = chm_pkg::ST_DONE;
                    end
                    else
                    begin
                        cmd.status = chm_pkg::ST_MISS;
                    end
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.status = (stat.in1 | stat.in2) ? chm_pkg::ST_DONE : chm_pkg::ST_MISS;
                end
            end
            S_KB_ST:
            begin
                cmd.mod_ck = 1'b1;
                state_next = S_KB_H1;
            end
            S_KB_H1:
            begin
                if (stat.mod_done)
                begin
                    cmd.mod_13 = 1'b1;
                    state_next = S_KB_H2;
                end
            end
            S_KB_H2:
            begin
                if (stat.mod_done)
                begin
                    cmd.set_s2 = 1'b1;
                    state_next = S_KB_RD;
                end
            end
            S_KB_RD:
            begin
                state_next = S_KB_CHK;
            end
            S_KB_CHK:
            begin
                cmd.put2 = 1'b1;
                if (!stat.rd2_valid)
                begin
                    cmd.cnt_inc = 1'b1;
                    cmd.finish  = 1'b1;
                    cmd.status  = chm_pkg::ST_DONE;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.round_inc = 1'b1;
                    state_next    = stat.round_last ? S_KICKED : S_KA_ST;
                end
            end
            S_KA_ST:
            begin
                cmd.mod_ck = 1'b1;
                state_next = S_KA_H;
            end
            S_KA_H:
            begin
                if (stat.mod_done)
                begin
                    cmd.set_s1 = 1'b1;
                    state_next = S_KA_RD;
                end
            end
            S_KA_RD:
            begin
                state_next = S_KA_CHK;
            end
            S_KA_CHK:
            begin
                cmd.put1 = 1'b1;
                if (!stat.rd1_valid)
                begin
                    cmd.cnt_inc = 1'b1;
                    cmd.finish  = 1'b1;
                    cmd.status  = chm_pkg::ST_DONE;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_KB_ST;
                end
            end
            S_KICKED:
            begin
                cmd.finish = 1'b1;
                cmd.status = chm_pkg::ST_KICK;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule
